// ===== rtl/core/interface_route_select_core_assert.svh =====
// assertion macros shared by the interface route select checks
`ifndef INTERFACE_ROUTE_SELECT_CORE_ASSERT_SVH
`define INTERFACE_ROUTE_SELECT_CORE_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define IRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define IRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/irs_pkg.sv =====
// shared types and constants for the interface route select block
package irs_pkg;

    localparam int IRS_MAX_IF = 8;
    localparam int SLOT_W     = 3;
    localparam int IP_W       = 32;
    localparam int ENTRY_W    = 3 * IP_W;

    localparam logic ACT_ADD    = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    typedef struct packed {
        logic            action;
        logic [IP_W-1:0] dest_address;
        logic [IP_W-1:0] entry_address;
        logic [IP_W-1:0] entry_mask;
        logic [IP_W-1:0] entry_gateway;
    } t_in_req;

    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              table_full;
    } t_out_res;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_POST = 3'b100
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic write;
        logic capture;
        logic push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_lookup;
        logic scan_done;
    } t_status;

endpackage

// ===== rtl/core/irs_ram.sv =====
// generic single write port ram with registered read
module irs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/irs_datapath.sv =====
// interface table storage, newest-first scan and result registers
module irs_datapath import irs_pkg::*; #(
    parameter int MAX_INTERFACES = IRS_MAX_IF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_in_req  i_req,
    input  t_cmd     i_cmd,
    output t_status  o_status,
    output t_out_res o_res
);

    localparam int IDX_W = (MAX_INTERFACES > 1) ? $clog2(MAX_INTERFACES) : 1;
    localparam int CNT_W = $clog2(MAX_INTERFACES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_INTERFACES);

    function automatic logic [SLOT_W-1:0] to_slot(input logic [IDX_W-1:0] idx);
        logic [IDX_W+SLOT_W-1:0] ext;
        ext = {{SLOT_W{1'b0}}, idx};
        return ext[SLOT_W-1:0];
    endfunction

    logic [CNT_W-1:0] r_used;
    t_in_req          r_req;
    logic             r_iss_busy;
    logic [IDX_W-1:0] r_iss_idx;
    logic             r_rd_valid;
    logic [IDX_W-1:0] r_rd_idx;
    logic             r_gw_found;
    logic [IDX_W-1:0] r_gw_idx;
    t_out_res         r_res;
    t_out_res         r_out;

    logic [ENTRY_W-1:0] w_rdata;
    logic [IP_W-1:0]    w_addr, w_mask, w_gw;
    logic               w_full, w_we;
    logic [IDX_W-1:0]   w_used_idx;
    logic [CNT_W-1:0]   w_used_m1;
    logic               w_sub_hit, w_gw_ok, w_last;
    t_out_res           w_result;

    assign w_full     = (r_used == FULL_CNT);
    assign w_used_idx = r_used[IDX_W-1:0];
    assign w_used_m1  = r_used - CNT_W'(1);
    assign w_we       = i_cmd.write && !w_full;

    irs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERFACES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_used_idx),
        .i_wdata ({r_req.entry_address, r_req.entry_mask, r_req.entry_gateway}),
        .i_re    (r_iss_busy),
        .i_raddr (r_iss_idx),
        .o_rdata (w_rdata)
    );

    assign w_addr = w_rdata[3*IP_W-1:2*IP_W];
    assign w_mask = w_rdata[2*IP_W-1:IP_W];
    assign w_gw   = w_rdata[IP_W-1:0];

    assign w_sub_hit = r_rd_valid && ((r_req.dest_address & w_mask) == (w_addr & w_mask));
    assign w_gw_ok   = r_rd_valid && (w_gw != '0) && ((w_gw & w_mask) == (w_addr & w_mask));
    assign w_last    = r_rd_valid && (r_rd_idx == '0);

    always_comb begin
        w_result = '0;
        if (r_req.action == ACT_ADD) begin
            w_result.hit        = !w_full;
            w_result.slot       = w_full ? '0 : to_slot(w_used_idx);
            w_result.table_full = w_full;
        end else if (w_sub_hit) begin
            w_result.hit  = 1'b1;
            w_result.slot = to_slot(r_rd_idx);
        end else if (r_gw_found) begin
            w_result.hit  = 1'b1;
            w_result.slot = to_slot(r_gw_idx);
        end else if (w_gw_ok) begin
            w_result.hit  = 1'b1;
            w_result.slot = to_slot(r_rd_idx);
        end
    end

    assign o_status.is_lookup = (r_req.action == ACT_LOOKUP);
    assign o_status.scan_done = (r_used == '0) || w_sub_hit || w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used     <= '0;
            r_iss_busy <= 1'b0;
            r_rd_valid <= 1'b0;
            r_gw_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_iss_busy <= (i_req.action == ACT_LOOKUP) && (r_used != '0);
            r_iss_idx  <= w_used_m1[IDX_W-1:0];
            r_rd_valid <= 1'b0;
            r_gw_found <= 1'b0;
        end else begin
            if (w_we) begin
                r_used <= r_used + CNT_W'(1);
            end
            if (r_iss_busy) begin
                r_iss_idx <= r_iss_idx - IDX_W'(1);
            end
            r_rd_idx <= r_iss_idx;
            // newest gateway candidate wins, kept in case no subnet match turns up
            if (w_gw_ok && !r_gw_found) begin
                r_gw_found <= 1'b1;
                r_gw_idx   <= r_rd_idx;
            end
            if (i_cmd.capture) begin
                r_iss_busy <= 1'b0;
                r_rd_valid <= 1'b0;
            end else begin
                if (r_iss_busy && (r_iss_idx == '0)) begin
                    r_iss_busy <= 1'b0;
                end
                r_rd_valid <= r_iss_busy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.capture) begin
            r_res <= w_result;
        end
        if (i_cmd.push) begin
            r_out <= r_res;
        end
    end

    assign o_res = r_out;

endmodule

// ===== rtl/core/irs_ctrl.sv =====
// request sequencing and output handshake controller
module irs_ctrl import irs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!i_status.is_lookup) begin
                    o_cmd.write   = 1'b1;
                    o_cmd.capture = 1'b1;
                    n_state       = ST_POST;
                end else if (i_status.scan_done) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_POST;
                end
            end
            ST_POST: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.push  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ===== rtl/core/interface_route_select_core.sv =====
// interface route select top: ipv4 interface table with newest-first subnet route lookup
// add: entry written unless full, result captured; next request taken once posted
// lookup: one table read a cycle, newest slot first, one ram port; the scan stops at the
//   first subnet match or the oldest slot; next request taken once the result is posted
// output register keeps a finished result while the next request is taken; stalls hold it
// reset (i_rst_n low, synchronous) empties the table and drops any pending result
module interface_route_select_core import irs_pkg::*; #(
    parameter int MAX_INTERFACES = IRS_MAX_IF
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    // request channel
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_req  i_in_data,
    // result channel
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_out_res o_out_data
);

    // command and status between sequencer and table datapath
    t_cmd    w_cmd;
    t_status w_status;

    // sequencer: idle, execute (write or scan), post result to output register
    irs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (w_cmd)
    );

    // table ram, scan pipeline with subnet and gateway compare, result registers
    irs_datapath #(
        .MAX_INTERFACES (MAX_INTERFACES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_in_data),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_res    (o_out_data)
    );

endmodule

// ===== rtl/core/irs_checker.sv =====
// port level checks for the interface route select top, bound to it
`include "interface_route_select_core_assert.svh"

module irs_checker import irs_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_in_valid,
    input logic     i_in_stall,
    input logic     i_out_valid,
    input logic     i_out_stall,
    input t_out_res i_out_data
);

    `IRS_ASSERT_NEXT(a_out_hold, i_out_valid && i_out_stall, i_out_valid && $stable(i_out_data), "stalled result changed")
    `IRS_ASSERT_NOW(a_full_no_hit, i_out_valid && i_out_data.table_full, !i_out_data.hit, "full refusal flagged as hit")
    `IRS_ASSERT_NOW(a_miss_slot, i_out_valid && !i_out_data.hit, i_out_data.slot == '0, "miss with nonzero slot")
    `IRS_ASSERT_NEXT(a_busy_after_req, i_in_valid && !i_in_stall, i_in_stall && !$rose(i_out_valid), "request not held off")

endmodule

bind interface_route_select_core irs_checker u_irs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_stall  (o_in_stall),
    .i_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .i_out_data  (o_out_data)
);
